@@ sv/isn_pkg.sv @@
// ---------------------------------------------------------------------------
// isn_pkg: shared constants and types for the integer square root core
// Widths of the root search, the radix-2 divider and the guess register.
// ---------------------------------------------------------------------------
`default_nettype none

package isn_pkg;

  localparam int INPUT_BITS   = 24;
  localparam int FRAC_BITS    = 20;
  localparam int NEWTON_STEPS = 10;
  localparam int OUT_BITS     = 32;

  // digit-by-digit integer root, two radicand bits per cycle
  localparam int ROOT_BITS     = (INPUT_BITS + 1) / 2;
  localparam int RAD_BITS      = 2 * ROOT_BITS;
  localparam int REM_BITS      = ROOT_BITS + 2;
  localparam int SQRT_CNT_BITS = $clog2(ROOT_BITS);

  // guess stays close to sqrt(value); a refinement step never leaves it at zero
  localparam int GUESS_BITS   = ROOT_BITS + FRAC_BITS + 2;
  localparam int QUO_BITS     = INPUT_BITS + FRAC_BITS + 1;
  localparam int DIV_ITERS    = INPUT_BITS + 2 * FRAC_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_ITERS);
  localparam int SUM_BITS     = ((GUESS_BITS > QUO_BITS) ? GUESS_BITS : QUO_BITS) + 1;
  localparam int SAT_BITS     = (GUESS_BITS > OUT_BITS) ? GUESS_BITS : OUT_BITS;
  localparam int STEP_BITS    = $clog2(NEWTON_STEPS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROOT,
    S_LOAD,
    S_DIV,
    S_FIN
  } isn_state_t;

  typedef struct packed {
    logic                 done;
    logic [ROOT_BITS-1:0] root;
    logic [REM_BITS-1:0]  rem;
  } isn_sqrt_res_t;

  typedef struct packed {
    logic                done;
    logic [QUO_BITS-1:0] quo;
  } isn_div_res_t;

endpackage

`default_nettype wire

@@ sv/isn_sqrt.sv @@
// ---------------------------------------------------------------------------
// isn_sqrt: digit-serial integer square root
// Restoring root extraction, one root bit per cycle; returns floor root and
// the remainder value - root^2.
// ---------------------------------------------------------------------------
`default_nettype none

module isn_sqrt
  import isn_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [INPUT_BITS-1:0] value,
  output isn_sqrt_res_t              res
);

  logic [RAD_BITS-1:0]      rad;
  logic [REM_BITS-1:0]      rem_q;
  logic [ROOT_BITS-1:0]     root_q;
  logic [SQRT_CNT_BITS-1:0] cnt;
  logic                     busy;
  logic                     done;

  logic [REM_BITS+1:0] rem_sh;
  logic [REM_BITS+1:0] trial;
  logic [REM_BITS+1:0] diff;
  logic                ge;

  always_comb begin
    rem_sh = {rem_q, rad[RAD_BITS-1 -: 2]};
    trial  = {2'b00, root_q, 2'b01};
    diff   = rem_sh - trial;
    ge     = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad    <= RAD_BITS'(value);
      rem_q  <= '0;
      root_q <= '0;
      cnt    <= SQRT_CNT_BITS'(ROOT_BITS - 1);
    end else if (busy) begin
      rad    <= {rad[RAD_BITS-3:0], 2'b00};
      rem_q  <= ge ? diff[REM_BITS-1:0] : rem_sh[REM_BITS-1:0];
      root_q <= {root_q[ROOT_BITS-2:0], ge};
      cnt    <= cnt - 1'b1;
    end
  end

  assign res.done = done;
  assign res.root = root_q;
  assign res.rem  = rem_q;

endmodule

`default_nettype wire

@@ sv/isn_div.sv @@
// ---------------------------------------------------------------------------
// isn_div: radix-2 restoring divider
// Computes floor(value * 2^(2*FRAC_BITS) / divisor), one quotient bit per
// cycle; the dividend is fed in msb first followed by zero bits.
// ---------------------------------------------------------------------------
`default_nettype none

module isn_div
  import isn_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [INPUT_BITS-1:0] value,
  input  wire logic [GUESS_BITS-1:0] divisor,
  output isn_div_res_t               res
);

  logic [INPUT_BITS-1:0]   num;
  logic [GUESS_BITS-1:0]   dvs;
  logic [GUESS_BITS-1:0]   rem_q;
  logic [QUO_BITS-1:0]     quo;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic                    busy;
  logic                    done;

  logic [GUESS_BITS:0] r_sh;
  logic [GUESS_BITS:0] diff;
  logic                ge;

  always_comb begin
    r_sh = {rem_q, num[INPUT_BITS-1]};
    diff = r_sh - {1'b0, dvs};
    ge   = (r_sh >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num   <= value;
      dvs   <= divisor;
      rem_q <= '0;
      quo   <= '0;
      cnt   <= DIV_CNT_BITS'(DIV_ITERS - 1);
    end else if (busy) begin
      num   <= {num[INPUT_BITS-2:0], 1'b0};
      rem_q <= ge ? diff[GUESS_BITS-1:0] : r_sh[GUESS_BITS-1:0];
      // leading quotient bits are always zero, they fall off the top
      quo   <= {quo[QUO_BITS-2:0], ge};
      cnt   <= cnt - 1'b1;
    end
  end

  assign res.done = done;
  assign res.quo  = quo;

endmodule

`default_nettype wire

@@ sv/integer_sqrt_newton_core.sv @@
// ---------------------------------------------------------------------------
// integer_sqrt_newton_core: square root in fixed point with 20 fraction bits
// Integer root search, then Babylonian refinement on a shared divider.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one request: value (24 bits).
//   Output channel out_valid/out_ready carries root_fixed (Q.20, saturated to
//   32 bits) and is_perfect_square.
//   One request is worked on at a time. in_ready is high only while the core
//   is idle; it may take a new request while the previous result still sits
//   in the output register.
//   Perfect squares (and zero) go from the root search straight to the
//   output stage. Other values run the root search and then ten divisions
//   on the radix-2 divider, each producing its quotient one bit at a time,
//   with a load state before each division and a guess update after it.
//   A new request is taken only after the previous one has left the
//   refinement loop and the core has returned to idle.
//   If the receiver stalls, the finished result waits inside the core until
//   the output register is free; nothing is dropped.
//   Reset (rst, synchronous) returns to idle and clears out_valid.
// ---------------------------------------------------------------------------
`default_nettype none

module integer_sqrt_newton_core
  import isn_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire logic [INPUT_BITS-1:0] value,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      logic [OUT_BITS-1:0]   root_fixed,
  output      logic                  is_perfect_square
);

  isn_state_t state;
  isn_state_t state_next;

  logic [INPUT_BITS-1:0] val_q;
  logic [GUESS_BITS-1:0] guess;
  logic [STEP_BITS-1:0]  step;
  logic                  perfect_q;

  isn_sqrt_res_t sq;
  isn_div_res_t  dv;

  logic sqrt_start;
  logic div_start;
  logic in_take;
  logic out_load;

  logic                  perfect;
  logic                  pick_top;
  logic [ROOT_BITS:0]    start_root;
  logic [GUESS_BITS-1:0] guess_init;
  logic [SUM_BITS-1:0]   half_sum;
  logic [GUESS_BITS-1:0] guess_new;
  logic [SAT_BITS-1:0]   guess_x;
  logic [OUT_BITS-1:0]   guess_sat;

  isn_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .value (val_q),
    .res   (sq)
  );

  isn_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .value   (val_q),
    .divisor (guess),
    .res     (dv)
  );

  always_comb begin
    perfect  = (sq.rem == '0);
    // above < below  <=>  2*root + 1 < 2*rem, a tie keeps the lower root
    pick_top = ({sq.rem, 1'b0} > {2'b00, sq.root, 1'b1});
    start_root = pick_top ? ({1'b0, sq.root} + 1'b1) : {1'b0, sq.root};
    guess_init = GUESS_BITS'(start_root) << FRAC_BITS;

    half_sum = SUM_BITS'(guess >> 1) + SUM_BITS'(dv.quo >> 1)
             + SUM_BITS'(guess[0] & dv.quo[0]);
    guess_new = GUESS_BITS'(half_sum);
    if (guess_new == '0) begin
      guess_new = GUESS_BITS'(1);
    end

    guess_x   = SAT_BITS'(guess);
    guess_sat = (guess_x > SAT_BITS'({OUT_BITS{1'b1}})) ? {OUT_BITS{1'b1}}
                                                         : guess_x[OUT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_ROOT;
        end
      end
      S_ROOT: begin
        if (sq.done) begin
          state_next = perfect ? S_FIN : S_LOAD;
        end
      end
      S_LOAD: begin
        div_start  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (dv.done) begin
          state_next = (step == STEP_BITS'(NEWTON_STEPS - 1)) ? S_FIN : S_LOAD;
        end
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_take = in_ready && in_valid;

  // root search starts the cycle after the request is latched
  always_ff @(posedge clk) begin
    if (rst) begin
      sqrt_start <= 1'b0;
    end else begin
      sqrt_start <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      val_q <= value;
    end
    if (state == S_ROOT && sq.done) begin
      perfect_q <= perfect;
      step      <= '0;
      guess     <= perfect ? (GUESS_BITS'(sq.root) << FRAC_BITS) : guess_init;
    end
    if (state == S_DIV && dv.done) begin
      guess <= guess_new;
      step  <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      root_fixed        <= guess_sat;
      is_perfect_square <= perfect_q;
    end
  end

endmodule

`default_nettype wire

@@ sv/isn_checker.sv @@
// ---------------------------------------------------------------------------
// isn_checker: port-level checks for integer_sqrt_newton_core
// Watches the two channels and the result fields over time.
// ---------------------------------------------------------------------------
`default_nettype none

module isn_checker
  import isn_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [OUT_BITS-1:0]   root_fixed,
  input wire logic                  is_perfect_square
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(root_fixed)
      && $stable(is_perfect_square))
    else $error("stalled result changed or dropped");

  // an exact root has no fraction bits
  a_perfect_frac: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_perfect_square |-> root_fixed[FRAC_BITS-1:0] == '0)
    else $error("perfect square flagged with fractional root");

  // one request in flight: busy right after accepting
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid set after reset");

  // a result never appears directly after a request is taken while out_valid is low
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared without work");

endmodule

bind integer_sqrt_newton_core isn_checker u_isn_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .root_fixed        (root_fixed),
  .is_perfect_square (is_perfect_square)
);

`default_nettype wire

@@ dv/tb_integer_sqrt_newton_core.sv @@
// ---------------------------------------------------------------------------
// tb_integer_sqrt_newton_core: self-checking bench for the integer sqrt core
// Drives integer requests through valid/ready with random gaps and stalls.
// A directed table covers zero, exact squares, the largest inputs and values
// on either side of the start-guess choice. Random requests follow. Every
// result is compared field by field with its typed answer or an in-bench Babylonian predictor.
// ---------------------------------------------------------------------------

module tb_integer_sqrt_newton_core;
  import isn_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RANDOM_REQUESTS = 1200;
  localparam int          MAX_WAIT        = 13;
  localparam int          DRAIN_CYCLES    = 40;
  localparam longint      CYCLE_LIMIT     = 4_000_000;
  localparam int          N_DIRECTED      = 24;

  typedef struct packed {
    logic [INPUT_BITS-1:0] value;
    logic [OUT_BITS-1:0]   root;
    logic                  perfect;
  } root_entry_t;

  typedef struct packed {
    logic                  typed;
    logic [INPUT_BITS-1:0] value;
    logic [OUT_BITS-1:0]   root;
    logic                  perfect;
  } directed_row_t;

  // typed rows carry their answer; the rest go through the predictor
  localparam directed_row_t DIRECTED [N_DIRECTED] = '{
    '{1'b1, 24'd0,        32'h0000_0000, 1'b1},
    '{1'b1, 24'd1,        32'h0010_0000, 1'b1},
    '{1'b1, 24'd4,        32'h0020_0000, 1'b1},
    '{1'b0, 24'd2,        32'h0,         1'b0},
    '{1'b0, 24'd3,        32'h0,         1'b0},
    '{1'b0, 24'd5,        32'h0,         1'b0},
    '{1'b0, 24'd8,        32'h0,         1'b0},
    '{1'b0, 24'd12,       32'h0,         1'b0},
    '{1'b0, 24'd13,       32'h0,         1'b0},
    '{1'b0, 24'd15,       32'h0,         1'b0},
    '{1'b1, 24'd16,       32'h0040_0000, 1'b1},
    '{1'b1, 24'd9000000,  32'hBB80_0000, 1'b1},
    '{1'b0, 24'd8999999,  32'h0,         1'b0},
    '{1'b0, 24'd9000001,  32'h0,         1'b0},
    '{1'b1, 24'd16769025, 32'hFFF0_0000, 1'b1},
    '{1'b0, 24'd16769024, 32'h0,         1'b0},
    '{1'b0, 24'd16769026, 32'h0,         1'b0},
    '{1'b0, 24'hFFFFFF,   32'h0,         1'b0},
    '{1'b0, 24'hFFFFFE,   32'h0,         1'b0},
    '{1'b0, 24'hAAAAAA,   32'h0,         1'b0},
    '{1'b0, 24'h555555,   32'h0,         1'b0},
    '{1'b0, 24'h800000,   32'h0,         1'b0},
    '{1'b0, 24'h7FFFFF,   32'h0,         1'b0},
    '{1'b1, 24'h400000,   32'h8000_0000, 1'b1}
  };

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [INPUT_BITS-1:0] value     = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [OUT_BITS-1:0]   root_fixed;
  logic                  is_perfect_square;

  root_entry_t expected_roots[$];
  int          mismatches  = 0;
  longint      cycle_count = 0;

  integer_sqrt_newton_core u_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .value             (value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .root_fixed        (root_fixed),
    .is_perfect_square (is_perfect_square)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still pending", $time, expected_roots.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // nearest integer start, then truncating Q.FRAC_BITS Babylonian steps
  function automatic root_entry_t babylonian_root(input logic [INPUT_BITS-1:0] v);
    longint unsigned vv;
    longint unsigned s;
    longint unsigned c;
    longint unsigned top;
    longint unsigned bot;
    longint unsigned above;
    longint unsigned below;
    longint unsigned g;
    longint unsigned q;
    root_entry_t     r;
    int              b;
    r.value   = v;
    r.root    = '0;
    r.perfect = 1'b1;
    vv = v;
    if (vv == 0) begin
      return r;
    end
    s = 0;
    for (b = 16; b >= 0; b--) begin
      c = s | (64'd1 << b);
      if (c * c <= vv) begin
        s = c;
      end
    end
    top = (s * s == vv) ? s : s + 1;
    if (top * top == vv) begin
      g = top << FRAC_BITS;
    end else begin
      r.perfect = 1'b0;
      bot   = top - 1;
      above = top * top - vv;
      below = vv - bot * bot;
      g = ((above < below) ? top : bot) << FRAC_BITS;
      for (b = 0; b < NEWTON_STEPS; b++) begin
        q = (vv << (2 * FRAC_BITS)) / g;
        g = (g >> 1) + (q >> 1) + (g & q & 64'd1);
        if (g == 0) begin
          g = 1;
        end
      end
    end
    r.root = (g > 64'hFFFF_FFFF) ? '1 : g[OUT_BITS-1:0];
    return r;
  endfunction

  // mostly plain values, with exact squares, near-squares and the top range mixed in
  function automatic logic [INPUT_BITS-1:0] pick_value();
    int unsigned sel;
    int unsigned r;
    longint      v;
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      r = $urandom_range(1, 4095);
      v = r * r;
    end else if (sel < 27) begin
      r = $urandom_range(1, 4095);
      v = longint'(r * r) + $urandom_range(0, 6) - 3;
    end else if (sel < 32) begin
      v = 24'hFFFFFF - $urandom_range(0, 9000);
    end else if (sel < 33) begin
      v = 0;
    end else begin
      v = $urandom_range(1, 24'hFFFFFF);
    end
    if (v < 0) begin
      v = 0;
    end else if (v > 24'hFFFFFF) begin
      v = 24'hFFFFFF;
    end
    return v[INPUT_BITS-1:0];
  endfunction

  // valid stays up across back-to-back requests; lowered only ahead of a gap
  task automatic send_request(input logic [INPUT_BITS-1:0] v, input int gap,
                              input root_entry_t expected);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_roots.push_back(expected);
  endtask

  initial begin
    root_entry_t exp_entry;
    int          gap;
    int          i;
    logic [INPUT_BITS-1:0] v;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED[i].typed) begin
        exp_entry.value   = DIRECTED[i].value;
        exp_entry.root    = DIRECTED[i].root;
        exp_entry.perfect = DIRECTED[i].perfect;
      end else begin
        exp_entry = babylonian_root(DIRECTED[i].value);
      end
      send_request(DIRECTED[i].value, $urandom_range(0, MAX_WAIT), exp_entry);
    end

    for (i = 0; i < RANDOM_REQUESTS; i++) begin
      v   = pick_value();
      // every third block of 100 requests runs back to back
      gap = ((i / 100) % 3 == 2) ? 0 : $urandom_range(0, MAX_WAIT);
      send_request(v, gap, babylonian_root(v));
    end
    in_valid <= 1'b0;

    while (expected_roots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    root_entry_t exp_entry;
    int          stall;
    int          served;
    served = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = ((served / 100) % 3 == 1) ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall == 0) begin
        out_ready <= 1'b1;
      end else begin
        // hold off until the result shows up, then make it wait
        out_ready <= 1'b0;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
        repeat (stall - 1) @(posedge clk);
        out_ready <= 1'b1;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      served++;
      if (expected_roots.size() == 0) begin
        $display("%0t: unexpected result root_fixed=%h is_perfect_square=%b",
                 $time, root_fixed, is_perfect_square);
        mismatches++;
      end else begin
        exp_entry = expected_roots.pop_front();
        if (root_fixed !== exp_entry.root) begin
          $display("%0t: root_fixed mismatch for value %0d: expected %h, actual %h",
                   $time, exp_entry.value, exp_entry.root, root_fixed);
          mismatches++;
        end
        if (is_perfect_square !== exp_entry.perfect) begin
          $display("%0t: is_perfect_square mismatch for value %0d: expected %b, actual %b",
                   $time, exp_entry.value, exp_entry.perfect, is_perfect_square);
          mismatches++;
        end
      end
    end
  end

endmodule

@@ files.f @@
sv/isn_pkg.sv
sv/isn_sqrt.sv
sv/isn_div.sv
sv/integer_sqrt_newton_core.sv
sv/isn_checker.sv
dv/tb_integer_sqrt_newton_core.sv
